/* rtl/cma_pkg.sv */
`default_nettype none

package cma_pkg;

  localparam int STAGES    = 16;
  localparam int TABLE_LEN = 24;
  localparam int SHIFT_W   = $clog2(TABLE_LEN);
  localparam int ROT_W     = 34;
  localparam int VEC_W     = 54;
  localparam int ZW        = 34;

  localparam logic signed [16:0] PI_A     = 17'sd12868;
  localparam logic signed [16:0] TWO_PI_A = 17'sd25736;

  localparam logic signed [ZW-1:0]    PI_Z       = 34'sd3373259426;
  localparam logic signed [ZW-1:0]    HALF_PI_Z  = 34'sd1686629713;
  localparam logic signed [ROT_W-1:0] GAIN_INV   = 34'sd652032874;
  localparam logic signed [ROT_W-1:0] SINE_ONE   = 34'sd16384;
  localparam logic signed [ROT_W-1:0] ROUND_SINE = 34'sd32768;
  localparam logic signed [ZW-1:0]    ROUND_ANG  = 34'sd131072;
  localparam logic signed [ZW-1:0]    PI_OUT     = 34'sd12868;

  localparam logic signed [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127
  };

  typedef struct packed {
    logic signed [15:0] angle;
    logic               last_sample;
  } in_t;

  typedef struct packed {
    logic signed [14:0] mean_angle;
    logic               mean_valid;
  } out_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ZW-1:0]    z;
    logic                    flip;
    logic                    last;
  } rot_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [ZW-1:0]    z;
    logic                    ok;
  } vec_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -33'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/cma_rot_cell.sv */
`default_nettype none

module cma_rot_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic [cma_pkg::SHIFT_W-1:0] shift,
  input  wire logic signed [cma_pkg::ZW-1:0] angle_step,
  input  wire logic                     vld_in,
  input  wire cma_pkg::rot_t            d_in,
  output logic                          vld,
  output cma_pkg::rot_t                 d
);
  import cma_pkg::*;

  rot_t d_next;

  always_comb begin
    d_next = d_in;
    if (d_in.z >= 0) begin
      d_next.x = d_in.x - (d_in.y >>> shift);
      d_next.y = d_in.y + (d_in.x >>> shift);
      d_next.z = d_in.z - angle_step;
    end else begin
      d_next.x = d_in.x + (d_in.y >>> shift);
      d_next.y = d_in.y - (d_in.x >>> shift);
      d_next.z = d_in.z + angle_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d <= d_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/cma_vec_cell.sv */
`default_nettype none

module cma_vec_cell (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic [cma_pkg::SHIFT_W-1:0] shift,
  input  wire logic signed [cma_pkg::ZW-1:0] angle_step,
  input  wire logic                     vld_in,
  input  wire cma_pkg::vec_t            d_in,
  output logic                          vld,
  output cma_pkg::vec_t                 d
);
  import cma_pkg::*;

  vec_t d_next;

  always_comb begin
    d_next = d_in;
    if (d_in.y > 0) begin
      d_next.x = d_in.x + (d_in.y >>> shift);
      d_next.y = d_in.y - (d_in.x >>> shift);
      d_next.z = d_in.z + angle_step;
    end else begin
      d_next.x = d_in.x - (d_in.y >>> shift);
      d_next.y = d_in.y + (d_in.x >>> shift);
      d_next.z = d_in.z - angle_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d <= d_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/circular_mean_angle_core.sv */
// Results pass the input, rotation, sine, sum, square and vectoring registers to out_valid.
// Throughput: one sample per cycle unless halted; two chains of 16 CORDIC cells, one accumulator.
// The chain halts only while a result waits in the output register and another reaches it.
// Reset (rst, synchronous, active high) clears all valid flags, both sums and the floor.
`default_nettype none

module circular_mean_angle_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire cma_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output cma_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [15:0]   cfg_wdata
);
  import cma_pkg::*;

  logic        advance;
  logic [31:0] floor_sq;

  logic        rot_v [STAGES+1];
  rot_t        rot_d [STAGES+1];
  logic        vec_v [STAGES+1];
  vec_t        vec_d [STAGES+1];

  logic signed [16:0]   a0, a1, a2;
  logic signed [ZW-1:0] z0;
  rot_t                 p0_next;

  logic signed [ROT_W-1:0] xr, yr, xc, yc;
  logic                    r_vld, r_last;
  logic signed [15:0]      r_s, r_c;

  logic signed [31:0] sine_sum, cosine_sum;
  logic signed [31:0] sine_total, cosine_total;
  logic               a_vld;
  logic signed [31:0] a_s, a_c;

  logic               m1_vld;
  logic signed [31:0] m1_s, m1_c;
  logic signed [63:0] prod_s, prod_c;
  logic [62:0]        m1_sq_s, m1_sq_c;

  logic [63:0]             mag2;
  logic signed [VEC_W-1:0] vx0, vy0;
  vec_t                    m2_next;

  logic signed [ZW-1:0] zr;
  logic signed [ZW-1:0] zc;
  out_t                 res;

  assign advance  = !(vec_v[STAGES] && out_valid && out_stall);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      floor_sq <= '0;
    end else if (cfg_we) begin
      floor_sq <= 32'(cfg_wdata) * 32'(cfg_wdata);
    end
  end

  always_comb begin
    a0 = 17'(in_data.angle);
    a1 = (a0 < -PI_A) ? a0 + TWO_PI_A : a0;
    a2 = (a1 > PI_A) ? a1 - TWO_PI_A : a1;
    z0 = ZW'(a2) <<< 18;
    p0_next.x    = GAIN_INV;
    p0_next.y    = '0;
    p0_next.last = in_data.last_sample;
    if (z0 > HALF_PI_Z) begin
      p0_next.z    = z0 - PI_Z;
      p0_next.flip = 1'b1;
    end else if (z0 < -HALF_PI_Z) begin
      p0_next.z    = z0 + PI_Z;
      p0_next.flip = 1'b1;
    end else begin
      p0_next.z    = z0;
      p0_next.flip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_v[0] <= 1'b0;
    end else if (advance) begin
      rot_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rot_d[0] <= p0_next;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    cma_rot_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (advance),
      .shift      (SHIFT_W'(i)),
      .angle_step (ATAN_Q30[i]),
      .vld_in     (rot_v[i]),
      .d_in       (rot_d[i]),
      .vld        (rot_v[i+1]),
      .d          (rot_d[i+1])
    );
  end

  always_comb begin
    xr = (rot_d[STAGES].x + ROUND_SINE) >>> 16;
    yr = (rot_d[STAGES].y + ROUND_SINE) >>> 16;
    xc = (xr > SINE_ONE) ? SINE_ONE : ((xr < -SINE_ONE) ? -SINE_ONE : xr);
    yc = (yr > SINE_ONE) ? SINE_ONE : ((yr < -SINE_ONE) ? -SINE_ONE : yr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (advance) begin
      r_vld <= rot_v[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_last <= rot_d[STAGES].last;
      r_s    <= rot_d[STAGES].flip ? -yc[15:0] : yc[15:0];
      r_c    <= rot_d[STAGES].flip ? -xc[15:0] : xc[15:0];
    end
  end

  assign sine_total   = sat32(33'(sine_sum) + 33'(r_s));
  assign cosine_total = sat32(33'(cosine_sum) + 33'(r_c));

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_sum   <= '0;
      cosine_sum <= '0;
      a_vld      <= 1'b0;
    end else if (advance) begin
      a_vld <= r_vld && r_last;
      if (r_vld) begin
        sine_sum   <= r_last ? '0 : sine_total;
        cosine_sum <= r_last ? '0 : cosine_total;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_s <= sine_total;
      a_c <= cosine_total;
    end
  end

  assign prod_s = a_s * a_s;
  assign prod_c = a_c * a_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (advance) begin
      m1_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m1_s    <= a_s;
      m1_c    <= a_c;
      m1_sq_s <= prod_s[62:0];
      m1_sq_c <= prod_c[62:0];
    end
  end

  always_comb begin
    mag2 = 64'(m1_sq_s) + 64'(m1_sq_c);
    vx0  = VEC_W'(m1_c) <<< 20;
    vy0  = VEC_W'(m1_s) <<< 20;
    m2_next.ok = mag2 > 64'(floor_sq);
    if (vx0 < 0) begin
      if (vy0 >= 0) begin
        m2_next.x = vy0;
        m2_next.y = -vx0;
        m2_next.z = HALF_PI_Z;
      end else begin
        m2_next.x = -vy0;
        m2_next.y = vx0;
        m2_next.z = -HALF_PI_Z;
      end
    end else begin
      m2_next.x = vx0;
      m2_next.y = vy0;
      m2_next.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vec_v[0] <= 1'b0;
    end else if (advance) begin
      vec_v[0] <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vec_d[0] <= m2_next;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_vec
    cma_vec_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (advance),
      .shift      (SHIFT_W'(i)),
      .angle_step (ATAN_Q30[i]),
      .vld_in     (vec_v[i]),
      .d_in       (vec_d[i]),
      .vld        (vec_v[i+1]),
      .d          (vec_d[i+1])
    );
  end

  always_comb begin
    zr = (vec_d[STAGES].z + ROUND_ANG) >>> 18;
    zc = (zr > PI_OUT) ? PI_OUT : ((zr < -PI_OUT) ? -PI_OUT : zr);
    res.mean_valid = vec_d[STAGES].ok;
    res.mean_angle = vec_d[STAGES].ok ? zc[14:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (out_valid && out_stall) || (advance && vec_v[STAGES]);
    end
  end

  always_ff @(posedge clk) begin
    if (advance && vec_v[STAGES]) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

/* rtl/cma_checker.sv */
`default_nettype none

module cma_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         in_valid,
  input wire logic         in_stall,
  input wire cma_pkg::in_t in_data,
  input wire logic         out_valid,
  input wire logic         out_stall,
  input wire cma_pkg::out_t out_data,
  input wire logic         cfg_we,
  input wire logic [15:0]  cfg_wdata
);
  import cma_pkg::*;

  // A transaction held on the output keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  // The input is held back only by a waiting, stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_no_mean_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.mean_valid |-> out_data.mean_angle == 15'sd0)
    else $error("undefined mean carries a nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.mean_angle <= 15'sd12868 && out_data.mean_angle >= -15'sd12868)
    else $error("mean angle outside of plus or minus pi");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present right after reset");

endmodule

bind circular_mean_angle_core cma_checker u_cma_checker (.*);

`default_nettype wire
